// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled while reset is applied
`define SRECT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment/box checker: property violated");

// Plain invariant checked every clock, disabled while reset is applied
`define SRECT_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("segment/box checker: invariant violated");

`endif

// ===== rtl/srect_pkg.sv =====
// Package: shared constants, flag types and the per-edge decision function
`timescale 1ns / 1ps

package srect_pkg;

    localparam int COORD_BITS_DEF = 16;

    // Endpoint pair versus one box boundary line
    typedef struct packed {
        logic all_lt;   // both endpoints below the boundary
        logic all_gt;   // both endpoints above the boundary
        logic all_on;   // both endpoints on the boundary
    } t_bnd;

    typedef struct packed {
        t_bnd lft;
        t_bnd rgt;
        t_bnd top;
        t_bnd bot;
        logic pt_in;    // an endpoint lies strictly within the box
        logic w_zero;
        logic h_zero;
    } t_flags;

    // One box edge against the segment.
    // ab_*: edge orientation of the two endpoints; c/d: segment orientation of the
    // edge's two corners; bbox: inclusive bounding boxes overlap.
    function automatic logic edge_meet(
        input logic ab_apart,
        input logic ab_zero,
        input logic c_neg,
        input logic c_zero,
        input logic d_neg,
        input logic d_zero,
        input logic bbox
    );
        logic cd_apart;
        cd_apart  = !c_zero && !d_zero && (c_neg == d_neg);
        edge_meet = !(ab_apart || cd_apart) && (!(ab_zero && c_zero && d_zero) || bbox);
    endfunction

endpackage

// ===== rtl/srect_front.sv =====
// Input register, boundary compares and cross-product terms, registered
`timescale 1ns / 1ps

module srect_front
    import srect_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DW = COORD_BITS + 2,
    localparam int PW = 2 * DW
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_take,
    input  logic signed [COORD_BITS-1:0] i_seg_start_x,
    input  logic signed [COORD_BITS-1:0] i_seg_start_y,
    input  logic signed [COORD_BITS-1:0] i_seg_end_x,
    input  logic signed [COORD_BITS-1:0] i_seg_end_y,
    input  logic signed [COORD_BITS-1:0] i_box_left,
    input  logic signed [COORD_BITS-1:0] i_box_top,
    input  logic        [COORD_BITS-2:0] i_box_width,
    input  logic        [COORD_BITS-2:0] i_box_height,
    output logic                         o_valid,
    output t_flags                       o_flags,
    output logic signed [PW-1:0]         o_px_l,
    output logic signed [PW-1:0]         o_px_r,
    output logic signed [PW-1:0]         o_py_t,
    output logic signed [PW-1:0]         o_py_b
);

    logic                         r_v0;
    logic signed [COORD_BITS-1:0] r_sx, r_sy, r_ex, r_ey, r_l, r_t;
    logic        [COORD_BITS-2:0] r_w, r_h;

    logic                         r_v1;
    t_flags                       r_flags;
    logic signed [PW-1:0]         r_px_l, r_px_r, r_py_t, r_py_b;

    logic signed [DW-1:0] sx_e, sy_e, ex_e, ey_e, l_e, t_e, r_e, b_e;
    logic signed [DW-1:0] du_l, du_r, dv_t, dv_b, dx, dy;
    logic signed [PW-1:0] n_px_l, n_px_r, n_py_t, n_py_b;
    t_flags               n_flags;
    logic                 s_in, e_in;

    // Right and bottom edges at full precision, two bits of headroom
    assign sx_e = DW'(r_sx);
    assign sy_e = DW'(r_sy);
    assign ex_e = DW'(r_ex);
    assign ey_e = DW'(r_ey);
    assign l_e  = DW'(r_l);
    assign t_e  = DW'(r_t);
    assign r_e  = l_e + $signed({3'b000, r_w});
    assign b_e  = t_e + $signed({3'b000, r_h});

    // orient(corner X,Y) = (sx - X) * dy - (sy - Y) * dx
    assign du_l = sx_e - l_e;
    assign du_r = sx_e - r_e;
    assign dv_t = sy_e - t_e;
    assign dv_b = sy_e - b_e;
    assign dx   = ex_e - sx_e;
    assign dy   = ey_e - sy_e;

    assign n_px_l = PW'(du_l) * PW'(dy);
    assign n_px_r = PW'(du_r) * PW'(dy);
    assign n_py_t = PW'(dv_t) * PW'(dx);
    assign n_py_b = PW'(dv_b) * PW'(dx);

    assign s_in = (sx_e > l_e) && (sx_e < r_e) && (sy_e > t_e) && (sy_e < b_e);
    assign e_in = (ex_e > l_e) && (ex_e < r_e) && (ey_e > t_e) && (ey_e < b_e);

    always_comb begin
        n_flags.lft.all_lt = (sx_e < l_e) && (ex_e < l_e);
        n_flags.lft.all_gt = (sx_e > l_e) && (ex_e > l_e);
        n_flags.lft.all_on = (sx_e == l_e) && (ex_e == l_e);
        n_flags.rgt.all_lt = (sx_e < r_e) && (ex_e < r_e);
        n_flags.rgt.all_gt = (sx_e > r_e) && (ex_e > r_e);
        n_flags.rgt.all_on = (sx_e == r_e) && (ex_e == r_e);
        n_flags.top.all_lt = (sy_e < t_e) && (ey_e < t_e);
        n_flags.top.all_gt = (sy_e > t_e) && (ey_e > t_e);
        n_flags.top.all_on = (sy_e == t_e) && (ey_e == t_e);
        n_flags.bot.all_lt = (sy_e < b_e) && (ey_e < b_e);
        n_flags.bot.all_gt = (sy_e > b_e) && (ey_e > b_e);
        n_flags.bot.all_on = (sy_e == b_e) && (ey_e == b_e);
        n_flags.pt_in      = s_in || e_in;
        n_flags.w_zero     = (r_w == '0);
        n_flags.h_zero     = (r_h == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= i_take;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_sx <= i_seg_start_x;
            r_sy <= i_seg_start_y;
            r_ex <= i_seg_end_x;
            r_ey <= i_seg_end_y;
            r_l  <= i_box_left;
            r_t  <= i_box_top;
            r_w  <= i_box_width;
            r_h  <= i_box_height;
        end
        if (r_v0) begin
            r_flags <= n_flags;
            r_px_l  <= n_px_l;
            r_px_r  <= n_px_r;
            r_py_t  <= n_py_t;
            r_py_b  <= n_py_b;
        end
    end

    assign o_valid = r_v1;
    assign o_flags = r_flags;
    assign o_px_l  = r_px_l;
    assign o_px_r  = r_px_r;
    assign o_py_t  = r_py_t;
    assign o_py_b  = r_py_b;

endmodule

// ===== rtl/srect_decide.sv =====
// Corner orientation signs, per-edge decisions and the result register
`timescale 1ns / 1ps

module srect_decide
    import srect_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DW = COORD_BITS + 2,
    localparam int PW = 2 * DW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_flags               i_flags,
    input  logic signed [PW-1:0] i_px_l,
    input  logic signed [PW-1:0] i_px_r,
    input  logic signed [PW-1:0] i_py_t,
    input  logic signed [PW-1:0] i_py_b,
    output logic                 o_done,
    output logic                 o_hit
);

    logic signed [PW:0] o_lt, o_lb, o_rb, o_rt;
    logic               lt_neg, lb_neg, rb_neg, rt_neg;
    logic               lt_zero, lb_zero, rb_zero, rt_zero;
    logic               m_left, m_bot, m_right, m_top;
    logic               n_hit;
    logic               r_done, r_hit;

    assign o_lt = (PW+1)'(i_px_l) - (PW+1)'(i_py_t);
    assign o_lb = (PW+1)'(i_px_l) - (PW+1)'(i_py_b);
    assign o_rb = (PW+1)'(i_px_r) - (PW+1)'(i_py_b);
    assign o_rt = (PW+1)'(i_px_r) - (PW+1)'(i_py_t);

    assign lt_neg  = o_lt[PW];
    assign lb_neg  = o_lb[PW];
    assign rb_neg  = o_rb[PW];
    assign rt_neg  = o_rt[PW];
    assign lt_zero = (o_lt == '0);
    assign lb_zero = (o_lb == '0);
    assign rb_zero = (o_rb == '0);
    assign rt_zero = (o_rt == '0);

    // Edge orientation of an endpoint against an axis-aligned edge reduces to a
    // coordinate compare, zero when the edge has no length
    always_comb begin
        m_left = edge_meet(
            !i_flags.h_zero && (i_flags.lft.all_lt || i_flags.lft.all_gt),
            i_flags.h_zero || i_flags.lft.all_on,
            lt_neg, lt_zero, lb_neg, lb_zero,
            !i_flags.lft.all_gt && !i_flags.lft.all_lt &&
            !i_flags.bot.all_gt && !i_flags.top.all_lt);
        m_bot = edge_meet(
            !i_flags.w_zero && (i_flags.bot.all_lt || i_flags.bot.all_gt),
            i_flags.w_zero || i_flags.bot.all_on,
            lb_neg, lb_zero, rb_neg, rb_zero,
            !i_flags.rgt.all_gt && !i_flags.lft.all_lt &&
            !i_flags.bot.all_gt && !i_flags.bot.all_lt);
        m_right = edge_meet(
            !i_flags.h_zero && (i_flags.rgt.all_lt || i_flags.rgt.all_gt),
            i_flags.h_zero || i_flags.rgt.all_on,
            rb_neg, rb_zero, rt_neg, rt_zero,
            !i_flags.rgt.all_gt && !i_flags.rgt.all_lt &&
            !i_flags.bot.all_gt && !i_flags.top.all_lt);
        m_top = edge_meet(
            !i_flags.w_zero && (i_flags.top.all_lt || i_flags.top.all_gt),
            i_flags.w_zero || i_flags.top.all_on,
            lt_neg, lt_zero, rt_neg, rt_zero,
            !i_flags.rgt.all_gt && !i_flags.lft.all_lt &&
            !i_flags.top.all_gt && !i_flags.top.all_lt);
        n_hit = i_flags.pt_in || m_left || m_bot || m_right || m_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_hit  <= 1'b0;
        end else begin
            r_done <= i_valid;
            r_hit  <= i_valid && n_hit;
        end
    end

    assign o_done = r_done;
    assign o_hit  = r_hit;

endmodule

// ===== rtl/segment_rectangle_intersect.sv =====
// Top level: segment versus axis-aligned box hit test
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  item in | start, busy         | i_seg_start/end_x/y, i_box_left/top/width/height
//  result  | o_done (one cycle)  | o_hit
//
// An accepted item passes the input, compare/multiply and result registers in turn.
// One item per cycle sustained; busy is always low, so start alone accepts.
// Reset is synchronous and clears only the pipeline valid bits and the result.
// The receiver cannot stall; every result is shown for exactly one cycle.
`timescale 1ns / 1ps

module segment_rectangle_intersect
    import srect_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_seg_start_x,
    input  logic signed [COORD_BITS-1:0] i_seg_start_y,
    input  logic signed [COORD_BITS-1:0] i_seg_end_x,
    input  logic signed [COORD_BITS-1:0] i_seg_end_y,
    input  logic signed [COORD_BITS-1:0] i_box_left,
    input  logic signed [COORD_BITS-1:0] i_box_top,
    input  logic        [COORD_BITS-2:0] i_box_width,
    input  logic        [COORD_BITS-2:0] i_box_height,
    output logic                         o_done,
    output logic                         o_hit
);

    localparam int PW = 2 * (COORD_BITS + 2);

    logic                 take;
    logic                 f_valid;
    t_flags               f_flags;
    logic signed [PW-1:0] f_px_l, f_px_r, f_py_t, f_py_b;

    assign busy = 1'b0;
    assign take = start && !busy;

    srect_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_seg_start_x (i_seg_start_x),
        .i_seg_start_y (i_seg_start_y),
        .i_seg_end_x   (i_seg_end_x),
        .i_seg_end_y   (i_seg_end_y),
        .i_box_left    (i_box_left),
        .i_box_top     (i_box_top),
        .i_box_width   (i_box_width),
        .i_box_height  (i_box_height),
        .o_valid       (f_valid),
        .o_flags       (f_flags),
        .o_px_l        (f_px_l),
        .o_px_r        (f_px_r),
        .o_py_t        (f_py_t),
        .o_py_b        (f_py_b)
    );

    srect_decide #(
        .COORD_BITS(COORD_BITS)
    ) u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_flags (f_flags),
        .i_px_l  (f_px_l),
        .i_px_r  (f_px_r),
        .i_py_t  (f_py_t),
        .i_py_b  (f_py_b),
        .o_done  (o_done),
        .o_hit   (o_hit)
    );

endmodule

// ===== rtl/srect_checker.sv =====
// Port-level checker for the segment/box hit test, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srect_checker
    import srect_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic signed [COORD_BITS-1:0] i_seg_start_x,
    input logic signed [COORD_BITS-1:0] i_seg_start_y,
    input logic signed [COORD_BITS-1:0] i_box_left,
    input logic signed [COORD_BITS-1:0] i_box_top,
    input logic                         o_done,
    input logic                         o_hit
);

    logic acc;
    logic corner_pt;

    assign acc       = start && !busy;
    // an endpoint sitting on the top-left corner always touches the box
    assign corner_pt = (i_seg_start_x == i_box_left) && (i_seg_start_y == i_box_top);

    `SRECT_ASSERT_IMP(a_done_follows, i_clk, i_rst_n, acc, ##3 o_done)
    `SRECT_ASSERT_IMP(a_done_has_item, i_clk, i_rst_n, o_done, $past(acc, 3))
    `SRECT_ASSERT_IMP(a_hit_only_done, i_clk, i_rst_n, !o_done, !o_hit)
    `SRECT_ASSERT_IMP(a_corner_hits, i_clk, i_rst_n, acc && corner_pt, ##3 o_hit)

endmodule

bind segment_rectangle_intersect srect_checker #(
    .COORD_BITS(COORD_BITS)
) u_srect_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_seg_start_x (i_seg_start_x),
    .i_seg_start_y (i_seg_start_y),
    .i_box_left    (i_box_left),
    .i_box_top     (i_box_top),
    .o_done        (o_done),
    .o_hit         (o_hit)
);

// ===== dv/tb_segment_rectangle_intersect.sv =====
// Testbench for segment_rectangle_intersect: directed and random hit queries, local predictor
`timescale 1ns / 1ps

module tb_segment_rectangle_intersect;

    import srect_pkg::*;

    localparam int CW = COORD_BITS_DEF;
    localparam int WW = CW - 1;

    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic signed [CW-1:0] left;
        logic signed [CW-1:0] top;
        logic        [WW-1:0] w;
        logic        [WW-1:0] h;
    } t_seg_box_query;

    typedef struct {
        t_seg_box_query q;
        logic           hit;
    } t_hit_expect;

    logic           i_clk     = 1'b0;
    logic           i_rst_n   = 1'b0;
    logic           start     = 1'b0;
    t_seg_box_query query_bus = '0;
    logic           busy;
    logic           o_done;
    logic           o_hit;

    t_hit_expect    expected_hits[$];
    t_hit_expect    oldest_hit;
    int             mismatches = 0;
    int             gap_pct    = 0;

    always #4 i_clk = ~i_clk;

    segment_rectangle_intersect #(
        .COORD_BITS(CW)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_seg_start_x(query_bus.sx),
        .i_seg_start_y(query_bus.sy),
        .i_seg_end_x  (query_bus.ex),
        .i_seg_end_y  (query_bus.ey),
        .i_box_left   (query_bus.left),
        .i_box_top    (query_bus.top),
        .i_box_width  (query_bus.w),
        .i_box_height (query_bus.h),
        .o_done       (o_done),
        .o_hit        (o_hit)
    );

    function automatic longint lmin(input longint a, input longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint lmax(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    // sign of (a - t) x (b - t)
    function automatic int cross_sign(input longint ax, input longint ay, input longint bx,
                                      input longint by, input longint tx, input longint ty);
        longint c;
        c = (ax - tx) * (by - ty) - (ay - ty) * (bx - tx);
        return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
    endfunction

    function automatic logic edge_crossed(input longint p1x, input longint p1y,
                                          input longint p2x, input longint p2y,
                                          input longint q1x, input longint q1y,
                                          input longint q2x, input longint q2y);
        int a, b, c, d;
        a = cross_sign(q1x, q1y, q2x, q2y, p1x, p1y);
        b = cross_sign(q1x, q1y, q2x, q2y, p2x, p2y);
        c = cross_sign(p1x, p1y, p2x, p2y, q1x, q1y);
        d = cross_sign(p1x, p1y, p2x, p2y, q2x, q2y);
        if (a * b > 0 || c * d > 0)
            return 1'b0;
        // collinear or point segments: inclusive bounding boxes must overlap
        if (a == 0 && b == 0 && c == 0 && d == 0)
            return lmin(p1x, p2x) <= lmax(q1x, q2x) && lmin(q1x, q2x) <= lmax(p1x, p2x) &&
                   lmin(p1y, p2y) <= lmax(q1y, q2y) && lmin(q1y, q2y) <= lmax(p1y, p2y);
        return 1'b1;
    endfunction

    function automatic logic point_inside(input longint x, input longint y, input longint l,
                                          input longint t, input longint r, input longint b);
        return x > l && x < r && y > t && y < b;
    endfunction

    function automatic logic predict_hit(input t_seg_box_query q);
        longint sx, sy, ex, ey, l, t, r, b;
        sx = $signed(q.sx);
        sy = $signed(q.sy);
        ex = $signed(q.ex);
        ey = $signed(q.ey);
        l  = $signed(q.left);
        t  = $signed(q.top);
        // right and bottom edges kept at full precision, no wrap
        r  = l + longint'(q.w);
        b  = t + longint'(q.h);
        return point_inside(sx, sy, l, t, r, b) || point_inside(ex, ey, l, t, r, b) ||
               edge_crossed(sx, sy, ex, ey, l, t, l, b) ||
               edge_crossed(sx, sy, ex, ey, l, b, r, b) ||
               edge_crossed(sx, sy, ex, ey, r, b, r, t) ||
               edge_crossed(sx, sy, ex, ey, l, t, r, t);
    endfunction

    function automatic t_seg_box_query make_query(input int sx, input int sy, input int ex,
                                                  input int ey, input int l, input int t,
                                                  input int w, input int h);
        t_seg_box_query q;
        q.sx   = CW'(sx);
        q.sy   = CW'(sy);
        q.ex   = CW'(ex);
        q.ey   = CW'(ey);
        q.left = CW'(l);
        q.top  = CW'(t);
        q.w    = WW'(w);
        q.h    = WW'(h);
        return q;
    endfunction

    function automatic t_seg_box_query rand_query();
        t_seg_box_query q;
        int mode, l, t, w, h;
        mode = $urandom_range(0, 9);
        if (mode < 3) begin
            // tight window: collinear, on-edge and degenerate cases turn up often
            q = make_query($urandom_range(0, 12) - 6, $urandom_range(0, 12) - 6,
                           $urandom_range(0, 12) - 6, $urandom_range(0, 12) - 6,
                           $urandom_range(0, 12) - 6, $urandom_range(0, 12) - 6,
                           $urandom_range(0, 6), $urandom_range(0, 6));
        end else if (mode < 5) begin
            q = make_query($urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
        end else begin
            l = $urandom_range(0, 65535) - 32768;
            t = $urandom_range(0, 65535) - 32768;
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 200);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 200);
            q = make_query(l + $urandom_range(0, w + 40) - 20, t + $urandom_range(0, h + 40) - 20,
                           l + $urandom_range(0, w + 40) - 20, t + $urandom_range(0, h + 40) - 20,
                           l, t, w, h);
            // lay the segment on the line of a box edge
            if (mode == 9) begin
                if ($urandom_range(0, 1) == 0) begin
                    q.sx = CW'(l);
                    q.ex = CW'(l);
                end else begin
                    q.sy = CW'(t + h);
                    q.ey = CW'(t + h);
                end
            end
        end
        return q;
    endfunction

    task automatic send_query(input t_seg_box_query q);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start     <= 1'b1;
        query_bus <= q;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic test_basic_geometry();
        send_query(make_query(1, 1, 2, 2, 0, 0, 10, 10));       // wholly inside
        send_query(make_query(20, 20, 30, 30, 0, 0, 10, 10));   // clear miss
        send_query(make_query(-5, 5, 15, 5, 0, 0, 10, 10));     // passes through
        send_query(make_query(0, 5, -5, 5, 0, 0, 10, 10));      // endpoint on left edge
        send_query(make_query(10, 10, 20, 20, 0, 0, 10, 10));   // endpoint on corner
        send_query(make_query(-3, 14, 14, -3, 0, 0, 10, 10));   // cuts a corner
        send_query(make_query(20, 0, 30, 0, 0, 0, 10, 10));     // collinear, apart
        send_query(make_query(5, 0, 30, 0, 0, 0, 10, 10));      // collinear, overlapping
        send_query(make_query(10, 0, 30, 0, 0, 0, 10, 10));     // collinear, touching
    endtask

    task automatic test_degenerate_shapes();
        send_query(make_query(-5, 5, 5, 5, 0, 0, 0, 10));       // zero width, crossed
        send_query(make_query(1, 1, 1, 9, 0, 0, 0, 10));        // zero width, parallel
        send_query(make_query(5, -5, 5, 5, 0, 0, 10, 0));       // zero height, crossed
        send_query(make_query(0, 0, 6, 6, 3, 3, 0, 0));         // point box on segment
        send_query(make_query(0, 0, 6, 5, 3, 3, 0, 0));         // point box off segment
        send_query(make_query(5, 5, 5, 5, 0, 0, 10, 10));       // point segment inside
        send_query(make_query(0, 5, 0, 5, 0, 0, 10, 10));       // point segment on edge
        send_query(make_query(11, 5, 11, 5, 0, 0, 10, 10));     // point segment outside
        send_query(make_query(3, 3, 3, 3, 3, 3, 0, 0));         // point on point
    endtask

    task automatic test_range_extremes();
        send_query(make_query(32767, 32767, -32768, -32768, 32767, 32767, 32767, 32767));
        send_query(make_query(-32768, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        send_query(make_query(-100, -100, -50, -50, -32768, -32768, 32767, 32767));
        send_query(make_query(-32768, 32767, 32767, -32768, 0, 0, 0, 0));
        send_query(make_query(32767, -32768, 32767, 32767, 32766, -32768, 32767, 0));
        send_query(make_query(-1, -1, -1, -1, -1, -1, 32767, 32767));
    endtask

    task automatic test_random_with_gaps(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0)
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 15;
                    default: gap_pct = 50;
                endcase
            send_query(rand_query());
        end
    endtask

    task automatic test_random_full_rate(input int n);
        gap_pct = 0;
        for (int i = 0; i < n; i++)
            send_query(rand_query());
    endtask

    // result check first, then record the item taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: result with nothing expected, hit %0b", $time, o_hit);
                    mismatches++;
                end else begin
                    oldest_hit = expected_hits.pop_front();
                    if (o_hit !== oldest_hit.hit) begin
                        $display("%0t: hit expected %0b actual %0b",
                                 $time, oldest_hit.hit, o_hit);
                        $display("    seg %0d,%0d to %0d,%0d box %0d,%0d size %0d x %0d",
                                 $signed(oldest_hit.q.sx), $signed(oldest_hit.q.sy),
                                 $signed(oldest_hit.q.ex), $signed(oldest_hit.q.ey),
                                 $signed(oldest_hit.q.left), $signed(oldest_hit.q.top),
                                 oldest_hit.q.w, oldest_hit.q.h);
                        mismatches++;
                    end
                end
            end else if (o_done !== 1'b0) begin
                $display("%0t: done strobe unknown, expected 0 or 1 actual %b", $time, o_done);
                mismatches++;
            end
            if (start === 1'b1 && busy === 1'b0)
                expected_hits.push_back('{q: query_bus, hit: predict_hit(query_bus)});
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gap_pct = 20;
        test_basic_geometry();
        test_degenerate_shapes();
        test_range_extremes();
        test_random_with_gaps(1200);
        test_random_full_rate(300);
        start <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout with %0d results outstanding", expected_hits.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
